// File: rtl/xor_sprite_framebuffer_macros.svh
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_macros.svh
// Assertion macros shared by the frame store RTL.
// ----------------------------------------------------------------------------
`ifndef XOR_SPRITE_FRAMEBUFFER_MACROS_SVH
`define XOR_SPRITE_FRAMEBUFFER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define XSFB_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("xsfb: implication check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define XSFB_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("xsfb: next-cycle check failed");

`endif

// File: rtl/xsfb_pkg.sv
// ----------------------------------------------------------------------------
// xsfb_pkg
// Shared types and constants of the XOR sprite frame store.
// ----------------------------------------------------------------------------
package xsfb_pkg;

    localparam int PIX_W    = 64;   // stored row word, bit 63 = column 0
    localparam int COORD_W  = 8;
    localparam int SPRITE_W = 8;
    localparam int RIDX_W   = 4;
    localparam int OP_W     = 2;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_DRAW  = 2'd0;
    localparam t_op OP_CLEAR = 2'd1;
    localparam t_op OP_READ  = 2'd2;

    // control from the sequencer to the row memory
    typedef struct packed {
        logic rd;   // capture a row word
        logic wr;   // write back a row word
        logic clr;  // drop every row to zero
    } t_mem_ctl;

endpackage

// File: rtl/xsfb_coord.sv
// ----------------------------------------------------------------------------
// xsfb_coord
// Row address and column mask generation with wrap at the screen edges.
// ----------------------------------------------------------------------------
module xsfb_coord #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int AW            = 5
) (
    input  logic [xsfb_pkg::COORD_W-1:0]  i_pos_x,
    input  logic [xsfb_pkg::COORD_W-1:0]  i_pos_y,
    input  logic [xsfb_pkg::RIDX_W-1:0]   i_row_ofs,
    input  logic [xsfb_pkg::SPRITE_W-1:0] i_sprite_row,
    output logic [AW-1:0]                 o_row_addr,
    output logic [xsfb_pkg::PIX_W-1:0]    o_bits
);

    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int SUM_W = 7;   // reduced row plus offset stays below 128

    // constant modulo tables
    logic [XW-1:0] xtab [256];
    logic [AW-1:0] ytab [256];
    logic [AW-1:0] rtab [128];

    for (genvar g = 0; g < 256; g++) begin : g_tab8
        assign xtab[g] = XW'(g % SCREEN_WIDTH);
        assign ytab[g] = AW'(g % SCREEN_HEIGHT);
    end
    for (genvar g = 0; g < 128; g++) begin : g_tab7
        assign rtab[g] = AW'(g % SCREEN_HEIGHT);
    end

    logic [SUM_W-1:0] row_sum;
    logic [XW-1:0]    x_base;

    assign row_sum    = SUM_W'(ytab[i_pos_y]) + SUM_W'(i_row_ofs);
    assign o_row_addr = rtab[row_sum];
    assign x_base     = xtab[i_pos_x];

    always_comb begin
        logic [XW:0]   col;
        logic [XW-1:0] col_w;
        o_bits = '0;
        for (int k = 0; k < 8; k++) begin
            col = (XW+1)'(x_base) + (XW+1)'(k);
            if (col >= (XW+1)'(SCREEN_WIDTH)) begin
                col = col - (XW+1)'(SCREEN_WIDTH);
            end
            col_w = col[XW-1:0];
            if (i_sprite_row[7-k]) begin
                o_bits[6'(63) - 6'(col_w)] = 1'b1;
            end
        end
    end

endmodule

// File: rtl/xsfb_row_mem.sv
// ----------------------------------------------------------------------------
// xsfb_row_mem
// Frame row memory, one word per screen row, with per-row valid bits.
// ----------------------------------------------------------------------------
module xsfb_row_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  xsfb_pkg::t_mem_ctl           i_ctl,
    input  logic [AW-1:0]                i_rd_addr,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [xsfb_pkg::PIX_W-1:0]   i_wr_data,
    output logic [xsfb_pkg::PIX_W-1:0]   o_rd_data
);

    logic [xsfb_pkg::PIX_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    logic [xsfb_pkg::PIX_W-1:0] r_rd_data;
    logic                       r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // an invalid row reads as cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.rd) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
            if (i_ctl.clr) begin
                r_valid <= '0;
            end else if (i_ctl.wr) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: rtl/xor_sprite_framebuffer.sv
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer
// Monochrome frame store with XOR sprite drawing, clear and row readback.
// ----------------------------------------------------------------------------
// The transfer cycle (start high, busy low) issues the row read for a draw
// or a read, and busy stays high for the next cycle, in which the row word
// comes back from the registered memory read and, for an in-range draw, the
// XORed word is written back. No new item is taken while busy is high. The
// result is marked by o_valid, which is high for exactly one cycle; o_valid
// rises at the edge where busy drops, so the result is taken at the rising
// edge that ends the o_valid strobe. There is no backpressure, so the
// receiver has to take it then.
// Clear is handled the same way: it drops per-row valid bits at once
// rather than sweeping the memory, and no clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "xor_sprite_framebuffer_macros.svh"

module xor_sprite_framebuffer #(
    parameter int SCREEN_WIDTH    = 64,
    parameter int SCREEN_HEIGHT   = 32,
    parameter int MAX_SPRITE_ROWS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [xsfb_pkg::OP_W-1:0]      i_operation,
    input  logic [xsfb_pkg::SPRITE_W-1:0]  i_sprite_row,
    input  logic [xsfb_pkg::COORD_W-1:0]   i_pos_x,
    input  logic [xsfb_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [xsfb_pkg::RIDX_W-1:0]    i_row_index,
    input  logic                           i_last_row,
    output logic                           o_valid,
    output logic [xsfb_pkg::PIX_W-1:0]     o_pixel_row,
    output logic                           o_collision,
    output logic                           o_sprite_done
);

    localparam int AW = $clog2(SCREEN_HEIGHT);

    // input transfer
    logic accept;
    assign accept = start && !busy;

    // a read addresses the start row itself
    logic [xsfb_pkg::RIDX_W-1:0] row_ofs;
    assign row_ofs = (i_operation == xsfb_pkg::OP_READ) ? '0 : i_row_index;

    logic [AW-1:0]              row_addr;
    logic [xsfb_pkg::PIX_W-1:0] bits;

    xsfb_coord #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .AW            (AW)
    ) u_coord (
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_row_ofs    (row_ofs),
        .i_sprite_row (i_sprite_row),
        .o_row_addr   (row_addr),
        .o_bits       (bits)
    );

    // item held for the write-back cycle
    logic                       r_busy;
    xsfb_pkg::t_op              r_op;
    logic [AW-1:0]              r_addr;
    logic [xsfb_pkg::PIX_W-1:0] r_bits;
    logic                       r_first;    // row index zero restarts the flag
    logic                       r_in_range; // row index below MAX_SPRITE_ROWS
    logic                       r_last;
    logic                       r_flag;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_operation;
            r_addr     <= row_addr;
            r_bits     <= bits;
            r_first    <= (i_row_index == '0);
            r_in_range <= (5'(i_row_index) < 5'(MAX_SPRITE_ROWS));
            r_last     <= i_last_row;
        end
    end

    // row memory
    xsfb_pkg::t_mem_ctl         mem_ctl;
    logic [xsfb_pkg::PIX_W-1:0] old_row;
    logic                       do_draw;

    assign do_draw     = r_busy && (r_op == xsfb_pkg::OP_DRAW) && r_in_range;
    assign mem_ctl.rd  = accept && (i_operation == xsfb_pkg::OP_DRAW
                                    || i_operation == xsfb_pkg::OP_READ);
    assign mem_ctl.clr = accept && (i_operation == xsfb_pkg::OP_CLEAR);
    assign mem_ctl.wr  = do_draw;

    xsfb_row_mem #(
        .DEPTH (SCREEN_HEIGHT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (row_addr),
        .i_wr_addr (r_addr),
        .i_wr_data (old_row ^ r_bits),
        .o_rd_data (old_row)
    );

    // modify step: collision flag and result fields
    logic                       n_flag;
    logic [xsfb_pkg::PIX_W-1:0] n_pixel_row;
    logic                       n_done;

    always_comb begin
        n_flag      = r_flag;
        n_pixel_row = '0;
        n_done      = 1'b0;
        case (r_op)
            xsfb_pkg::OP_DRAW: begin
                if (r_in_range) begin
                    n_flag = (r_flag && !r_first) || (|(old_row & r_bits));
                end
                n_done = r_last;
            end
            xsfb_pkg::OP_READ: begin
                n_pixel_row = old_row;
            end
            default: begin
                n_flag = r_flag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_flag  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_busy  <= accept;
            o_valid <= r_busy;
            if (r_busy) begin
                r_flag <= n_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            o_pixel_row   <= n_pixel_row;
            o_collision   <= n_flag;
            o_sprite_done <= n_done;
        end
    end

    assign busy = r_busy;

    // checks
    `XSFB_ASSERT_NEXT(a_accept_busy, accept, r_busy)
    `XSFB_ASSERT_NEXT(a_busy_result, r_busy, o_valid && !r_busy)
    `XSFB_ASSERT_IMPL(a_wr_only_busy, mem_ctl.wr, r_busy && !mem_ctl.clr)
    `XSFB_ASSERT_IMPL(a_done_no_row, o_valid && o_sprite_done, o_pixel_row == '0)

endmodule

// File: tb/xor_sprite_framebuffer_tb.sv
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_tb
// Self-checking bench for the XOR sprite frame store. A driver presents
// draw, clear, read and op-3 commands on the start/busy handshake with random
// idle gaps. A monitor keeps a shadow copy of the frame and the erase flag,
// predicts each result at transfer time and checks the o_valid strobes in
// order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module xor_sprite_framebuffer_tb;

    localparam int SCREEN_WIDTH    = 64;
    localparam int SCREEN_HEIGHT   = 32;
    localparam int MAX_SPRITE_ROWS = 16;

    // op code 3 has no package name; the block must treat it as a no-op
    localparam xsfb_pkg::t_op OP_NOP = 2'd3;

    localparam int RANDOM_CMDS = 1650;
    localparam int MAX_GAP     = 16;
    localparam int DRAIN_CYCLES = 20;     // result trails transfer through r_busy and o_valid
    localparam int CYCLE_LIMIT  = 300000; // far above what ~1700 cmds with their gaps need
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        xsfb_pkg::t_op                 op;
        logic [xsfb_pkg::SPRITE_W-1:0] sprite;
        logic [xsfb_pkg::COORD_W-1:0]  px;
        logic [xsfb_pkg::COORD_W-1:0]  py;
        logic [xsfb_pkg::RIDX_W-1:0]   ridx;
        logic                          last;
    } t_fb_cmd;

    typedef struct packed {
        logic [xsfb_pkg::PIX_W-1:0] pixel_row;
        logic                       collision;
        logic                       sprite_done;
    } t_frame_answer;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    xsfb_pkg::t_op                 i_operation;
    logic [xsfb_pkg::SPRITE_W-1:0] i_sprite_row;
    logic [xsfb_pkg::COORD_W-1:0]  i_pos_x;
    logic [xsfb_pkg::COORD_W-1:0]  i_pos_y;
    logic [xsfb_pkg::RIDX_W-1:0]   i_row_index;
    logic                          i_last_row;
    logic                          o_valid;
    logic [xsfb_pkg::PIX_W-1:0]    o_pixel_row;
    logic                          o_collision;
    logic                          o_sprite_done;

    xor_sprite_framebuffer #(
        .SCREEN_WIDTH    (SCREEN_WIDTH),
        .SCREEN_HEIGHT   (SCREEN_HEIGHT),
        .MAX_SPRITE_ROWS (MAX_SPRITE_ROWS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_sprite_row  (i_sprite_row),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_row_index   (i_row_index),
        .i_last_row    (i_last_row),
        .o_valid       (o_valid),
        .o_pixel_row   (o_pixel_row),
        .o_collision   (o_collision),
        .o_sprite_done (o_sprite_done)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_fb_cmd       cmd_q[$];          // commands waiting for the driver
    t_frame_answer frame_answer_q[$]; // predicted results, oldest first

    logic [xsfb_pkg::PIX_W-1:0] shadow_rows [SCREEN_HEIGHT];
    logic                       shadow_erase;

    logic xfer_seen;                  // a transfer happened at the last rising edge
    int   gap_left;
    int   burst_left;
    bit   burst_idle;
    int   fail_cnt;
    int   cycle_cnt;

    // ------------------------------------------------------------------
    // Shadow frame: apply one command, return what the block should say
    // ------------------------------------------------------------------
    function automatic t_frame_answer frame_apply(input t_fb_cmd c);
        t_frame_answer              ans;
        logic [xsfb_pkg::PIX_W-1:0] bits;
        logic [xsfb_pkg::PIX_W-1:0] old_row;
        int unsigned                row;
        int unsigned                col;
        ans = '0;
        case (c.op)
            xsfb_pkg::OP_DRAW: begin
                if (c.ridx < MAX_SPRITE_ROWS) begin
                    row  = ((c.py % SCREEN_HEIGHT) + c.ridx) % SCREEN_HEIGHT;
                    bits = '0;
                    // bit 7 lands on the start column, each pixel wraps on its own
                    for (int k = 0; k < 8; k++) begin
                        if (c.sprite[7-k]) begin
                            col = ((c.px % SCREEN_WIDTH) + k) % SCREEN_WIDTH;
                            bits[xsfb_pkg::PIX_W-1-col] = 1'b1;
                        end
                    end
                    old_row = shadow_rows[row];
                    if (c.ridx == '0)
                        shadow_erase = 1'b0;
                    if ((old_row & bits) != '0)
                        shadow_erase = 1'b1;
                    shadow_rows[row] = old_row ^ bits;
                end
                ans.sprite_done = c.last;
            end
            xsfb_pkg::OP_CLEAR: begin
                // erase flag survives a clear
                foreach (shadow_rows[i])
                    shadow_rows[i] = '0;
            end
            xsfb_pkg::OP_READ: begin
                ans.pixel_row = shadow_rows[c.py % SCREEN_HEIGHT];
            end
            default: begin
                // OP_NOP: nothing moves
            end
        endcase
        ans.collision = shadow_erase;
        return ans;
    endfunction

    // idle gap before the next command; each burst is randomly either
    // back-to-back traffic or random idling
    function automatic int next_gap();
        if (burst_left == 0) begin
            burst_left = $urandom_range(20, 80);
            burst_idle = 1'($urandom_range(0, 1));
        end
        burst_left--;
        return burst_idle ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    task automatic push_cmd(input xsfb_pkg::t_op op, input int sprite, input int px,
                            input int py, input int ridx, input int last);
        t_fb_cmd c;
        c.op     = op;
        c.sprite = sprite[xsfb_pkg::SPRITE_W-1:0];
        c.px     = px[xsfb_pkg::COORD_W-1:0];
        c.py     = py[xsfb_pkg::COORD_W-1:0];
        c.ridx   = ridx[xsfb_pkg::RIDX_W-1:0];
        c.last   = last[0];
        cmd_q.push_back(c);
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle counter
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        cycle_cnt <= cycle_cnt + 1;

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("xor_sprite_framebuffer verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: inputs move on the falling edge. A command stays on the bus
    // until a transfer is seen, then the next one follows after its gap.
    // Fields carry noise while start is low.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_fb_cmd nxt;
        logic    waiting;
        waiting = start && !xfer_seen;
        if (!i_rst_n || waiting) begin
            // hold
        end else if (gap_left != 0 || cmd_q.size() == 0) begin
            if (gap_left != 0)
                gap_left <= gap_left - 1;
            start        <= 1'b0;
            i_operation  <= xsfb_pkg::t_op'($urandom_range(0, 3));
            i_sprite_row <= 8'($urandom_range(0, 255));
            i_pos_x      <= 8'($urandom_range(0, 255));
            i_pos_y      <= 8'($urandom_range(0, 255));
            i_row_index  <= 4'($urandom_range(0, 15));
            i_last_row   <= 1'($urandom_range(0, 1));
        end else begin
            nxt          = cmd_q.pop_front();
            start        <= 1'b1;
            i_operation  <= nxt.op;
            i_sprite_row <= nxt.sprite;
            i_pos_x      <= nxt.px;
            i_pos_y      <= nxt.py;
            i_row_index  <= nxt.ridx;
            i_last_row   <= nxt.last;
            gap_left     <= next_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: on each rising edge, predict any transfer and check any
    // strobed result against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_fb_cmd       seen;
        t_frame_answer want;
        xfer_seen <= i_rst_n && start && !busy;
        if (i_rst_n && start && busy === 1'b0) begin
            seen.op     = i_operation;
            seen.sprite = i_sprite_row;
            seen.px     = i_pos_x;
            seen.py     = i_pos_y;
            seen.ridx   = i_row_index;
            seen.last   = i_last_row;
            frame_answer_q.push_back(frame_apply(seen));
        end
        if (i_rst_n && o_valid === 1'b1) begin
            if (frame_answer_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX)
                    $display("[%0t] unexpected result: row=%h coll=%b done=%b",
                             $realtime, o_pixel_row, o_collision, o_sprite_done);
            end else begin
                want = frame_answer_q.pop_front();
                if (o_pixel_row !== want.pixel_row || o_collision !== want.collision ||
                    o_sprite_done !== want.sprite_done) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display({"[%0t] mismatch: row exp %h got %h, ",
                                  "coll exp %b got %b, done exp %b got %b"},
                                 $realtime, want.pixel_row, o_pixel_row, want.collision,
                                 o_collision, want.sprite_done, o_sprite_done);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int n_cmds;
        int pick;
        int rows;
        int sx;
        int sy;
        int keep_x;
        int keep_y;
        int keep_rows;
        int keep_bytes[16];

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_operation  = xsfb_pkg::OP_DRAW;
        i_sprite_row = '0;
        i_pos_x      = '0;
        i_pos_y      = '0;
        i_row_index  = '0;
        i_last_row   = 1'b0;
        xfer_seen    = 1'b0;
        gap_left     = 0;
        burst_left   = 0;
        burst_idle   = 0;
        fail_cnt     = 0;
        cycle_cnt    = 0;
        shadow_erase = 1'b0;
        foreach (shadow_rows[i])
            shadow_rows[i] = '0;

        // directed: empty read, plain draws, collision, both wraps,
        // out-of-range coordinates, clear keeping the flag, op 3, extremes
        push_cmd(xsfb_pkg::OP_READ,  0,    0,   0,   0,  0);
        push_cmd(xsfb_pkg::OP_DRAW,  8'hFF, 0,  0,   0,  0);
        push_cmd(xsfb_pkg::OP_DRAW,  8'h81, 0,  0,   1,  1);
        push_cmd(xsfb_pkg::OP_READ,  0,    0,   0,   0,  0);
        push_cmd(xsfb_pkg::OP_READ,  0,    0,   1,   0,  0);
        push_cmd(xsfb_pkg::OP_DRAW,  8'h80, 0,  0,   0,  1);   // erases column 0
        push_cmd(xsfb_pkg::OP_DRAW,  8'hFF, 60, 31,  3,  0);   // wraps right edge and bottom
        push_cmd(xsfb_pkg::OP_READ,  0,    0,   34,  0,  0);
        push_cmd(xsfb_pkg::OP_DRAW,  8'hA5, 255, 255, 15, 1);  // coordinates taken modulo size
        push_cmd(xsfb_pkg::OP_READ,  0,    0,   46,  0,  0);
        push_cmd(xsfb_pkg::OP_CLEAR, 0,    0,   0,   0,  0);
        push_cmd(xsfb_pkg::OP_READ,  0,    0,   14,  0,  0);
        push_cmd(OP_NOP,             8'h5A, 17, 99,  7,  1);
        push_cmd(xsfb_pkg::OP_DRAW,  8'h00, 0,  0,   0,  0);
        push_cmd(xsfb_pkg::OP_DRAW,  8'h01, 7,  31,  0,  1);
        push_cmd(xsfb_pkg::OP_READ,  0,    0,   31,  0,  0);
        push_cmd(OP_NOP,             8'hFF, 255, 255, 15, 1);
        push_cmd(xsfb_pkg::OP_READ,  8'hFF, 255, 255, 15, 1);
        push_cmd(xsfb_pkg::OP_CLEAR, 8'hFF, 255, 255, 15, 1);
        push_cmd(xsfb_pkg::OP_READ,  0,    0,   0,   0,  0);

        // random: mostly whole sprites, some redrawn in place to erase them,
        // mixed with reads, rare clears, op 3 and loose draw rows
        n_cmds    = 0;
        keep_rows = 0;
        while (n_cmds < RANDOM_CMDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if (keep_rows != 0 && $urandom_range(0, 4) == 0) begin
                    rows = keep_rows;
                    sx   = keep_x;
                    sy   = keep_y;
                end else begin
                    rows = $urandom_range(1, MAX_SPRITE_ROWS);
                    sx   = $urandom_range(0, 255);
                    sy   = $urandom_range(0, 255);
                    for (int r = 0; r < rows; r++)
                        keep_bytes[r] = $urandom_range(0, 255);
                end
                for (int r = 0; r < rows; r++)
                    push_cmd(xsfb_pkg::OP_DRAW, keep_bytes[r], sx, sy, r,
                             int'(r == rows - 1));
                keep_rows = rows;
                keep_x    = sx;
                keep_y    = sy;
                n_cmds    += rows;
            end else if (pick < 85) begin
                push_cmd(xsfb_pkg::OP_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 15),
                         $urandom_range(0, 1));
                n_cmds++;
            end else if (pick < 87) begin
                push_cmd(xsfb_pkg::OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 15),
                         $urandom_range(0, 1));
                n_cmds++;
            end else if (pick < 90) begin
                push_cmd(OP_NOP, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 15),
                         $urandom_range(0, 1));
                n_cmds++;
            end else begin
                push_cmd(xsfb_pkg::OP_DRAW, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 15),
                         $urandom_range(0, 1));
                n_cmds++;
            end
        end

        // synchronous reset, released on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent, every transfer answered
        @(posedge i_clk);
        while (cmd_q.size() != 0 || start || frame_answer_q.size() != 0)
            @(posedge i_clk);
        // catch any stray strobe
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0 && frame_answer_q.size() == 0)
            $display("xor_sprite_framebuffer verification clean");
        else
            $display("xor_sprite_framebuffer verification failed");
        $finish;
    end

endmodule
